// ----- src/pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types, widths and constants of the pendulum cart derivative pipeline.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int NUM_W     = 38;   // signed numerator width
  localparam int MAG_W     = NUM_W - 1;
  localparam int DEN_W     = 26;
  localparam int IDX_W     = 4;
  localparam int CFG_W     = 32;

  // Pipeline stage map
  localparam int N_STAGES    = 27;
  localparam int SINE_STAGES = 7;
  localparam int ST_PROD     = 7;
  localparam int ST_SUM      = 8;
  localparam int ST_DIV      = 9;
  localparam int DIV_STAGES  = N_STAGES - ST_DIV;

  // Gravity, rounded to the fixed-point grid
  localparam logic [19:0] GRAV = 20'(((981 * (1 << FRAC_BITS)) + 50) / 100);

  typedef enum logic [IDX_W-1:0] {
    REG_CART_MASS    = 4'd0,
    REG_LINK1_MASS   = 4'd1,
    REG_LINK2_MASS   = 4'd2,
    REG_LINK3_MASS   = 4'd3,
    REG_LINK1_LENGTH = 4'd4,
    REG_LINK2_LENGTH = 4'd5,
    REG_LINK3_LENGTH = 4'd6,
    REG_FRICTION     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [22:0] cart_mass;
    logic [19:0] link1_mass;
    logic [19:0] link2_mass;
    logic [19:0] link3_mass;
    logic [18:0] link1_length;
    logic [18:0] link2_length;
    logic [18:0] link3_length;
    logic [19:0] friction;
  } cfg_regs_t;

  // Terms that follow from the registers alone
  typedef struct packed {
    logic [23:0]      mt;
    logic [27:0]      mg;
    logic [28:0]      ga1;
    logic [28:0]      ga2;
    logic [28:0]      ga3;
    logic [24:0]      g2;
    logic [22:0]      g3;
    logic [DEN_W-1:0] den1;
    logic [DEN_W-1:0] den2;
    logic [DEN_W-1:0] den3;
  } coef_t;

endpackage

// ----- src/pcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcd_ctrl
// Valid bits and per-stage load enables of the pipeline; bubbles collapse.
// ----------------------------------------------------------------------------
module pcd_ctrl import pcd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_stall,
  output logic [N_STAGES-1:0] en,
  output logic                in_stall,
  output logic                out_valid
);

  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] vld_next;

  // A stage loads unless it and every stage after it hold an item and the
  // output is stalled.
  for (genvar i = 0; i < N_STAGES; i++) begin : g_en
    assign en[i] = !(&vld[N_STAGES-1:i]) || !out_stall;
  end

  always_comb begin
    vld_next[0] = en[0] ? in_valid : vld[0];
    for (int i = 1; i < N_STAGES; i++) begin
      vld_next[i] = en[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[N_STAGES-1];

endmodule

// ----- src/pcd_sine.sv -----
// ----------------------------------------------------------------------------
// pcd_sine
// Pipelined sine (or cosine) of a Q15.16 angle: phase in turns, quarter-wave
// fold, odd degree-9 polynomial in Horner form, one multiply per stage.
// ----------------------------------------------------------------------------
module pcd_sine import pcd_pkg::*; (
  input  logic                    clk,
  input  logic [SINE_STAGES-1:0]  en,
  input  logic signed [WORD_W-1:0] angle,
  input  logic                    quarter,
  output logic                    neg,
  output logic [FRAC_BITS:0]      mag
);

  localparam logic [29:0] TURN_SCALE = 30'd683565276;
  localparam logic [30:0] Q30_ONE    = 31'd1073741824;
  localparam logic [30:0] SC1        = 31'd1686629713;
  localparam logic [29:0] SC3        = 30'd693598668;
  localparam logic [26:0] SC5        = 27'd85569306;
  localparam logic [22:0] SC7        = 23'd5026995;
  localparam logic [17:0] SC9        = 18'd172273;
  localparam logic [32:0] RND        = 33'(1 << (29 - FRAC_BITS));
  localparam logic [18:0] ONE        = 19'(1 << FRAC_BITS);

  logic signed [62:0] ph_prod;
  logic [31:0]        phase;
  logic [1:0]         quad_c;
  logic [30:0]        x_c;
  logic [61:0]        sq;
  logic [48:0]        m9;
  logic [53:0]        m7;
  logic [57:0]        m5;
  logic [60:0]        m3;
  logic [61:0]        sp;
  logic [32:0]        rsum;
  logic [18:0]        rr;

  logic [30:0] x_q  [1:5];
  logic [30:0] x2_q [1:4];
  logic [1:0]  qd_q [1:5];
  logic [22:0] p7;
  logic [26:0] p5;
  logic [29:0] p3;
  logic [30:0] p1;

  assign ph_prod = angle * $signed({1'b0, TURN_SCALE});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      phase <= ph_prod[FRAC_BITS+31:FRAC_BITS];
    end
  end

  // Fold to the first quarter wave
  always_comb begin
    quad_c = phase[31:30] + {1'b0, quarter};
    x_c    = quad_c[0] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    sq     = x_c * x_c;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_q[1]  <= x_c;
      x2_q[1] <= sq[60:30];
      qd_q[1] <= quad_c;
    end
  end

  assign m9 = x2_q[1] * SC9;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x_q[2]  <= x_q[1];
      x2_q[2] <= x2_q[1];
      qd_q[2] <= qd_q[1];
      p7      <= SC7 - 23'(m9[48:30]);
    end
  end

  assign m7 = x2_q[2] * p7;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x_q[3]  <= x_q[2];
      x2_q[3] <= x2_q[2];
      qd_q[3] <= qd_q[2];
      p5      <= SC5 - 27'(m7[53:30]);
    end
  end

  assign m5 = x2_q[3] * p5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      x_q[4]  <= x_q[3];
      x2_q[4] <= x2_q[3];
      qd_q[4] <= qd_q[3];
      p3      <= SC3 - 30'(m5[57:30]);
    end
  end

  assign m3 = x2_q[4] * p3;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      x_q[5]  <= x_q[4];
      qd_q[5] <= qd_q[4];
      p1      <= SC1 - m3[60:30];
    end
  end

  // Final product, round to the output grid and cap at one
  always_comb begin
    sp   = x_q[5] * p1;
    rsum = {1'b0, sp[61:30]} + RND;
    rr   = rsum[32:30-FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      neg <= qd_q[5][1];
      mag <= (rr > ONE) ? ONE[FRAC_BITS:0] : rr[FRAC_BITS:0];
    end
  end

endmodule

// ----- src/pcd_coef.sv -----
// ----------------------------------------------------------------------------
// pcd_coef
// Free-running three-stage pipeline of the mass, length and gravity terms.
// ----------------------------------------------------------------------------
module pcd_coef import pcd_pkg::*; (
  input  logic      clk,
  input  cfg_regs_t cfg,
  output coef_t     coef
);

  // floor(n / 3) for n below 2^25: reciprocal multiply
  function automatic logic [22:0] div3(input logic [23:0] n);
    logic [47:0] p;
    p = n * 24'd11184811;
    return p[47:25];
  endfunction

  logic [21:0] km1, j1;
  logic [20:0] k2;
  logic [18:0] k3;
  logic [23:0] mt1, mt2;
  logic [18:0] l1_1, l2_1, l3_1;
  logic [19:0] m2_1, m3_1;

  logic [24:0] a1, a2, a3, d1;
  logic [22:0] p2, p3, q3;

  always_ff @(posedge clk) begin
    km1  <= 22'(cfg.link1_mass >> 1) + 22'(cfg.link2_mass) + 22'(cfg.link3_mass);
    k2   <= 21'(cfg.link2_mass >> 1) + 21'(cfg.link3_mass);
    k3   <= cfg.link3_mass[19:1];
    mt1  <= 24'(cfg.cart_mass) + 24'(cfg.link1_mass) + 24'(cfg.link2_mass)
          + 24'(cfg.link3_mass);
    j1   <= 22'(div3(24'(cfg.link1_mass))) + 22'(cfg.link2_mass)
          + 22'(cfg.link3_mass);
    l1_1 <= cfg.link1_length;
    l2_1 <= cfg.link2_length;
    l3_1 <= cfg.link3_length;
    m2_1 <= cfg.link2_mass;
    m3_1 <= cfg.link3_mass;
  end

  always_ff @(posedge clk) begin
    a1        <= 25'((41'(km1) * 41'(l1_1)) >> FRAC_BITS);
    a2        <= 25'((40'(k2) * 40'(l2_1)) >> FRAC_BITS);
    a3        <= 25'((38'(k3) * 38'(l3_1)) >> FRAC_BITS);
    d1        <= 25'((41'(j1) * 41'(l1_1)) >> FRAC_BITS);
    p2        <= 23'((39'(m2_1) * 39'(l2_1)) >> FRAC_BITS);
    p3        <= 23'((39'(m3_1) * 39'(l2_1)) >> FRAC_BITS);
    q3        <= 23'((39'(m3_1) * 39'(l3_1)) >> FRAC_BITS);
    mt2       <= mt1;
  end

  always_ff @(posedge clk) begin
    coef.mt   <= mt2;
    coef.mg   <= 28'((44'(mt1) * 44'(GRAV)) >> FRAC_BITS);
    coef.g2   <= 25'((41'(k2) * 41'(GRAV)) >> FRAC_BITS);
    coef.g3   <= 23'((39'(k3) * 39'(GRAV)) >> FRAC_BITS);
    coef.ga1  <= 29'((45'(a1) * 45'(GRAV)) >> FRAC_BITS);
    coef.ga2  <= 29'((45'(a2) * 45'(GRAV)) >> FRAC_BITS);
    coef.ga3  <= 29'((45'(a3) * 45'(GRAV)) >> FRAC_BITS);
    coef.den1 <= DEN_W'(d1);
    coef.den2 <= DEN_W'(div3(24'(p2))) + DEN_W'(p3);
    coef.den3 <= DEN_W'(div3(24'(q3)));
  end

endmodule

// ----- src/pcd_div.sv -----
// ----------------------------------------------------------------------------
// pcd_div
// Pipelined saturating fixed-point divider: (num << FRAC_BITS) / den,
// truncated toward zero, two quotient bits per stage.
// ----------------------------------------------------------------------------
module pcd_div import pcd_pkg::*; (
  input  logic                     clk,
  input  logic [DIV_STAGES-1:0]    en,
  input  logic signed [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]         den,
  output logic signed [WORD_W-1:0] res,
  output logic                     sat
);

  localparam int STEPS = DIV_STAGES - 2;

  // One restoring step: shift in a dividend bit, subtract where it fits
  function automatic logic [DEN_W:0] dstep(input logic [DEN_W-1:0] r,
                                           input logic b,
                                           input logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    t    = {r, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[DEN_W-1:0]};
    end else begin
      return {1'b0, t[DEN_W-1:0]};
    end
  endfunction

  logic [MAG_W-1:0] mag_c;

  logic [DEN_W-1:0]     rem_q [0:STEPS];
  logic [WORD_W-1:0]    quo_q [0:STEPS];
  logic [FRAC_BITS-1:0] lo_q  [0:STEPS];
  logic [DEN_W-1:0]     den_q [0:STEPS];
  logic                 neg_q [0:STEPS];
  logic                 zero_q[0:STEPS];
  logic                 ovf_q [0:STEPS];

  assign mag_c = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

  // Prepare: quotient overflows 32 bits where the integer part reaches den
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_q[0]  <= DEN_W'(mag_c[MAG_W-1:FRAC_BITS]);
      quo_q[0]  <= '0;
      lo_q[0]   <= mag_c[FRAC_BITS-1:0];
      den_q[0]  <= den;
      neg_q[0]  <= num[NUM_W-1];
      zero_q[0] <= (mag_c == '0);
      ovf_q[0]  <= ({{(DEN_W+FRAC_BITS-MAG_W){1'b0}}, mag_c[MAG_W-1:FRAC_BITS]} >= den);
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [DEN_W:0] s1, s2;

    always_comb begin
      s1 = dstep(rem_q[k], lo_q[k][FRAC_BITS-1], den_q[k]);
      s2 = dstep(s1[DEN_W-1:0], lo_q[k][FRAC_BITS-2], den_q[k]);
    end

    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        rem_q[k+1]  <= s2[DEN_W-1:0];
        quo_q[k+1]  <= {quo_q[k][WORD_W-3:0], s1[DEN_W], s2[DEN_W]};
        lo_q[k+1]   <= {lo_q[k][FRAC_BITS-3:0], 2'b00};
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end
  end

  logic [WORD_W-1:0] lim;
  logic [WORD_W-1:0] quo;

  assign quo = quo_q[STEPS];
  assign lim = neg_q[STEPS] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};

  // Saturate to the word limit, then apply the sign
  always_ff @(posedge clk) begin
    if (en[DIV_STAGES-1]) begin
      priority if (zero_q[STEPS]) begin
        res <= '0;
        sat <= 1'b0;
      end else if (ovf_q[STEPS] || (quo > lim)) begin
        res <= lim;
        sat <= 1'b1;
      end else begin
        res <= neg_q[STEPS] ? -quo : quo;
        sat <= 1'b0;
      end
    end
  end

endmodule

// ----- src/pendulum_cart_derivatives.sv -----
// ----------------------------------------------------------------------------
// pendulum_cart_derivatives
// State derivative of a cart carrying a three-link pendulum, Q15.16 fixed
// point, fully pipelined.
// ----------------------------------------------------------------------------
// Use: present an item on the input channel (in_valid with the eight fields);
// it transfers at a rising edge with in_valid high and in_stall low. The
// result leaves on the output channel under out_valid, and transfers when
// out_stall is low. One item can transfer on every cycle in which in_stall
// is low, so throughput is one item per cycle unless the pipeline backs up.
// The depth is set by the sine pipelines (seven multiply stages) and the
// dividers, which retire two quotient bits a stage over sixteen stages.
// While the receiver stalls, the output register holds its result and the
// earlier stages keep filling empty slots; in_stall rises only once every
// stage holds an item. Registers are to be written over the cfg channel
// (always ready) only while the block is idle, which it does not enforce.
// Reset empties the pipeline and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module pendulum_cart_derivatives import pcd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WORD_W-1:0] cart_velocity,
  input  logic signed [WORD_W-1:0] angle_one,
  input  logic signed [WORD_W-1:0] rate_one,
  input  logic signed [WORD_W-1:0] angle_two,
  input  logic signed [WORD_W-1:0] rate_two,
  input  logic signed [WORD_W-1:0] angle_three,
  input  logic signed [WORD_W-1:0] rate_three,
  input  logic signed [WORD_W-1:0] force_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] position_slope,
  output logic signed [WORD_W-1:0] cart_accel,
  output logic signed [WORD_W-1:0] angle_one_slope,
  output logic signed [WORD_W-1:0] accel_one,
  output logic signed [WORD_W-1:0] angle_two_slope,
  output logic signed [WORD_W-1:0] accel_two,
  output logic signed [WORD_W-1:0] angle_three_slope,
  output logic signed [WORD_W-1:0] accel_three,
  output logic                     saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  typedef struct packed {
    logic signed [WORD_W-1:0] vel;
    logic signed [WORD_W-1:0] r1;
    logic signed [WORD_W-1:0] r2;
    logic signed [WORD_W-1:0] r3;
  } pass_t;

  function automatic logic [WORD_W-1:0] abs_w(input logic signed [WORD_W-1:0] x);
    return x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
  endfunction

  function automatic logic signed [NUM_W-1:0] signed_num(input logic n,
                                                         input logic [MAG_W-1:0] m);
    logic signed [NUM_W-1:0] e;
    e = $signed({1'b0, m});
    return n ? -e : e;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_regs_t cfg;
  coef_t     coef;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cart_mass    <= 23'd65536;
      cfg.link1_mass   <= 20'd6554;
      cfg.link2_mass   <= 20'd5243;
      cfg.link3_mass   <= 20'd3277;
      cfg.link1_length <= 19'd32768;
      cfg.link2_length <= 19'd19661;
      cfg.link3_length <= 19'd13107;
      cfg.friction     <= 20'd6554;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CART_MASS:    cfg.cart_mass    <= cfg_data[22:0];
        REG_LINK1_MASS:   cfg.link1_mass   <= cfg_data[19:0];
        REG_LINK2_MASS:   cfg.link2_mass   <= cfg_data[19:0];
        REG_LINK3_MASS:   cfg.link3_mass   <= cfg_data[19:0];
        REG_LINK1_LENGTH: cfg.link1_length <= cfg_data[18:0];
        REG_LINK2_LENGTH: cfg.link2_length <= cfg_data[18:0];
        REG_LINK3_LENGTH: cfg.link3_length <= cfg_data[18:0];
        REG_FRICTION:     cfg.friction     <= cfg_data[19:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  pcd_coef u_coef (
    .clk  (clk),
    .cfg  (cfg),
    .coef (coef)
  );

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic [N_STAGES-1:0] en;

  pcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .en        (en),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // --------------------------------------------------------------------------
  // Pass-through fields and force
  // --------------------------------------------------------------------------
  pass_t                    pass_q  [0:N_STAGES-1];
  logic signed [WORD_W-1:0] force_q [0:ST_SUM-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pass_q[0]  <= '{vel: cart_velocity, r1: rate_one, r2: rate_two, r3: rate_three};
      force_q[0] <= force_req;
    end
    for (int i = 1; i < N_STAGES; i++) begin
      if (en[i]) begin
        pass_q[i] <= pass_q[i-1];
      end
    end
    for (int i = 1; i < ST_SUM; i++) begin
      if (en[i]) begin
        force_q[i] <= force_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sines and cosine
  // --------------------------------------------------------------------------
  logic                 s1_neg, c1_neg, s2_neg, s3_neg;
  logic [FRAC_BITS:0]   s1_mag, c1_mag, s2_mag, s3_mag;

  pcd_sine u_sin1 (.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(angle_one),
                   .quarter(1'b0), .neg(s1_neg), .mag(s1_mag));
  pcd_sine u_cos1 (.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(angle_one),
                   .quarter(1'b1), .neg(c1_neg), .mag(c1_mag));
  pcd_sine u_sin2 (.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(angle_two),
                   .quarter(1'b0), .neg(s2_neg), .mag(s2_mag));
  pcd_sine u_sin3 (.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(angle_three),
                   .quarter(1'b0), .neg(s3_neg), .mag(s3_mag));

  // --------------------------------------------------------------------------
  // Products, sign-magnitude, truncated toward zero
  // --------------------------------------------------------------------------
  logic [51:0] vb_p;
  logic [45:0] t1_p, t2_p, t3_p;
  logic [44:0] u1_p;
  logic [48:0] u2_p;
  logic [41:0] n2_p;
  logic [39:0] n3_p;
  logic signed [WORD_W-1:0] vel6, frc6;

  assign vel6 = pass_q[ST_PROD-1].vel;
  assign frc6 = force_q[ST_PROD-1];

  always_comb begin
    vb_p = abs_w(vel6) * cfg.friction;
    t1_p = coef.ga1 * s1_mag;
    t2_p = coef.ga2 * s2_mag;
    t3_p = coef.ga3 * s3_mag;
    u1_p = coef.mg * s1_mag;
    u2_p = abs_w(frc6) * c1_mag;
    n2_p = coef.g2 * s2_mag;
    n3_p = coef.g3 * s3_mag;
  end

  logic signed [NUM_W-1:0] tvb, t1, t2, t3, u1, u2, n2, n3;

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      tvb <= signed_num(vel6[WORD_W-1], MAG_W'(vb_p[51:FRAC_BITS]));
      t1  <= signed_num(s1_neg, MAG_W'(t1_p[45:FRAC_BITS]));
      t2  <= signed_num(s2_neg, MAG_W'(t2_p[45:FRAC_BITS]));
      t3  <= signed_num(s3_neg, MAG_W'(t3_p[45:FRAC_BITS]));
      u1  <= signed_num(s1_neg, MAG_W'(u1_p[44:FRAC_BITS]));
      u2  <= signed_num(frc6[WORD_W-1] ^ c1_neg, MAG_W'(u2_p[48:FRAC_BITS]));
      n2  <= signed_num(s2_neg, MAG_W'(n2_p[41:FRAC_BITS]));
      n3  <= signed_num(s3_neg, MAG_W'(n3_p[39:FRAC_BITS]));
    end
  end

  // --------------------------------------------------------------------------
  // Numerators
  // --------------------------------------------------------------------------
  logic signed [NUM_W-1:0] num_x, num_1, num_2, num_3;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      num_x <= NUM_W'(force_q[ST_SUM-1]) - tvb + t1 + t2 + t3;
      num_1 <= u1 - u2;
      num_2 <= n2;
      num_3 <= n3;
    end
  end

  // --------------------------------------------------------------------------
  // Quotients
  // --------------------------------------------------------------------------
  logic sat_x, sat_1, sat_2, sat_3;

  pcd_div u_div_x (.clk(clk), .en(en[N_STAGES-1:ST_DIV]), .num(num_x),
                   .den(DEN_W'(coef.mt)), .res(cart_accel), .sat(sat_x));
  pcd_div u_div_1 (.clk(clk), .en(en[N_STAGES-1:ST_DIV]), .num(num_1),
                   .den(coef.den1), .res(accel_one), .sat(sat_1));
  pcd_div u_div_2 (.clk(clk), .en(en[N_STAGES-1:ST_DIV]), .num(num_2),
                   .den(coef.den2), .res(accel_two), .sat(sat_2));
  pcd_div u_div_3 (.clk(clk), .en(en[N_STAGES-1:ST_DIV]), .num(num_3),
                   .den(coef.den3), .res(accel_three), .sat(sat_3));

  assign saturated         = sat_x || sat_1 || sat_2 || sat_3;
  assign position_slope    = pass_q[N_STAGES-1].vel;
  assign angle_one_slope   = pass_q[N_STAGES-1].r1;
  assign angle_two_slope   = pass_q[N_STAGES-1].r2;
  assign angle_three_slope = pass_q[N_STAGES-1].r3;

`ifndef SYNTHESIS
  // Input backs up only when the whole pipe is full and the output stalled
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  // A saturated result carries at least one acceleration at a word limit
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (cart_accel == 32'sh7FFFFFFF || cart_accel == 32'sh80000000 ||
       accel_one == 32'sh7FFFFFFF || accel_one == 32'sh80000000 ||
       accel_two == 32'sh7FFFFFFF || accel_two == 32'sh80000000 ||
       accel_three == 32'sh7FFFFFFF || accel_three == 32'sh80000000))
    else $error("saturated flag without a clipped acceleration");

  // Reset empties the pipeline
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result presented straight after reset");
`endif

endmodule
